// ===== hdl/tlep_pkg.sv =====
`default_nettype none
package tlep_pkg;

	localparam int MAX_RESULTS = 64;
	localparam int PLAN_CNT_W  = $clog2(MAX_RESULTS);

	typedef logic [2:0] req_t;
	localparam req_t REQ_PUT         = 3'd0;
	localparam req_t REQ_ACCESS      = 3'd1;
	localparam req_t REQ_DELETE      = 3'd2;
	localparam req_t REQ_EVICT_KEY   = 3'd3;
	localparam req_t REQ_PROMOTE     = 3'd4;
	localparam req_t REQ_EVICT_BYTES = 3'd5;

	typedef logic [1:0] status_t;
	localparam status_t ST_DONE     = 2'd0;
	localparam status_t ST_NONE     = 2'd1;
	localparam status_t ST_BAD_TIER = 2'd2;
	localparam status_t ST_FULL     = 2'd3;

	typedef logic [1:0] reg_addr_t;
	localparam reg_addr_t REG_TIERS      = 2'd0;
	localparam reg_addr_t REG_FREE_ONE   = 2'd1;
	localparam reg_addr_t REG_FREE_TWO   = 2'd2;
	localparam reg_addr_t REG_FREE_THREE = 2'd3;

	typedef struct packed {
		logic [2:0]  tiers_in_use;
		logic [31:0] free_one;
		logic [31:0] free_two;
		logic [31:0] free_three;
	} cfg_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_SCAN_INIT,
		OP_SCAN,
		OP_ENT_RD,
		OP_UNLINK,
		OP_APPEND1,
		OP_APPEND2,
		OP_PLAN_RD,
		OP_PLAN_EMIT,
		OP_EB_INIT,
		OP_EB_EMIT,
		OP_EMIT_STATUS
	} dp_op_t;

	typedef struct packed {
		dp_op_t  op;
		status_t code;
	} dp_cmd_t;

	typedef struct packed {
		req_t req;
		logic bad_req;
		logic bad_tier;
		logic ek_empty;
		logic pr_empty;
		logic eb_empty;
		logic scan_hit;
		logic scan_done;
		logic free_found;
		logic eb_last;
		logic slot_free;
	} dp_stat_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_SCAN,
		S_ENT_RD,
		S_UNLINK,
		S_APPEND1,
		S_APPEND2,
		S_PLAN_EMIT,
		S_EB_EMIT,
		S_EMIT_STATUS
	} ctrl_state_t;

endpackage
`default_nettype wire

// ===== hdl/tiered_lru_eviction_planner.sv =====
`default_nettype none
// Plans key movement between storage tiers from per-tier LRU lists held in an
// ENTRIES-slot store. One request is worked at a time; the input stays stalled
// from its acceptance until the next request can be taken. Put, access and delete
// look the key up by scanning the store one slot per cycle through its single
// read port and stop at a hit; a miss scans the whole store, and a put that misses
// claims a free slot. Evict-bytes walks the LRU chain one link per cycle, one plan
// per link, while the receiver does not stall. Each result waits in an output
// register until taken, and a waiting result holds back the next; nothing needs
// clearing after reset.
module tiered_lru_eviction_planner #(
	parameter int ENTRIES   = 64,
	parameter int NUM_TIERS = 4,
	parameter int KEY_BITS  = 32
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                psel,
	input  wire logic                penable,
	input  wire logic                pwrite,
	input  wire logic [3:0]          paddr,
	input  wire logic [31:0]         pwdata,
	output logic [31:0]              prdata,
	output logic                     pready,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic [2:0]          req_type,
	input  wire logic [KEY_BITS-1:0] key_id,
	input  wire logic [1:0]          tier_sel,
	input  wire logic [31:0]         item_size,
	input  wire logic [31:0]         bytes_wanted,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic [1:0]               status,
	output logic                     plan_valid,
	output logic [KEY_BITS-1:0]      plan_key,
	output logic [1:0]               source_tier,
	output logic [1:0]               dest_tier,
	output logic                     discard,
	output logic                     last
);

	tlep_pkg::cfg_t     cfg;
	tlep_pkg::dp_cmd_t  cmd;
	tlep_pkg::dp_stat_t stat;

	tlep_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	tlep_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.cmd      (cmd),
		.stat     (stat)
	);

	tlep_dp #(
		.ENTRIES   (ENTRIES),
		.NUM_TIERS (NUM_TIERS),
		.KEY_BITS  (KEY_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.cmd          (cmd),
		.stat         (stat),
		.req_type     (req_type),
		.key_id       (key_id),
		.tier_sel     (tier_sel),
		.item_size    (item_size),
		.bytes_wanted (bytes_wanted),
		.out_stall    (out_stall),
		.out_valid    (out_valid),
		.status       (status),
		.plan_valid   (plan_valid),
		.plan_key     (plan_key),
		.source_tier  (source_tier),
		.dest_tier    (dest_tier),
		.discard      (discard),
		.last         (last)
	);

endmodule
`default_nettype wire

// ===== hdl/tlep_regs.sv =====
`default_nettype none
module tlep_regs (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          psel,
	input  wire logic          penable,
	input  wire logic          pwrite,
	input  wire logic [3:0]    paddr,
	input  wire logic [31:0]   pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	output tlep_pkg::cfg_t     cfg
);

	tlep_pkg::cfg_t cfg_q;
	tlep_pkg::reg_addr_t ra;

	assign ra     = paddr[3:2];
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tiers_in_use <= 3'd1;
			cfg_q.free_one     <= '0;
			cfg_q.free_two     <= '0;
			cfg_q.free_three   <= '0;
		end else if (psel && penable && pwrite) begin
			unique case (ra)
				tlep_pkg::REG_TIERS:      cfg_q.tiers_in_use <= pwdata[2:0];
				tlep_pkg::REG_FREE_ONE:   cfg_q.free_one     <= pwdata;
				tlep_pkg::REG_FREE_TWO:   cfg_q.free_two     <= pwdata;
				tlep_pkg::REG_FREE_THREE: cfg_q.free_three   <= pwdata;
			endcase
		end
	end

	always_comb begin
		unique case (ra)
			tlep_pkg::REG_TIERS:      prdata = {29'd0, cfg_q.tiers_in_use};
			tlep_pkg::REG_FREE_ONE:   prdata = cfg_q.free_one;
			tlep_pkg::REG_FREE_TWO:   prdata = cfg_q.free_two;
			tlep_pkg::REG_FREE_THREE: prdata = cfg_q.free_three;
		endcase
	end

endmodule
`default_nettype wire

// ===== hdl/tlep_ctrl.sv =====
`default_nettype none
module tlep_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_stall,
	output tlep_pkg::dp_cmd_t   cmd,
	input  wire tlep_pkg::dp_stat_t stat
);

	tlep_pkg::ctrl_state_t state_q, state_d;
	tlep_pkg::status_t     code_q, code_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tlep_pkg::S_IDLE;
			code_q  <= tlep_pkg::ST_DONE;
		end else begin
			state_q <= state_d;
			code_q  <= code_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		code_d   = code_q;
		cmd.op   = tlep_pkg::OP_NONE;
		cmd.code = code_q;
		in_stall = 1'b1;
		unique case (state_q)
			tlep_pkg::S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.op  = tlep_pkg::OP_LOAD;
					state_d = tlep_pkg::S_DECODE;
				end
			end
			tlep_pkg::S_DECODE: begin
				if (stat.bad_req) begin
					code_d  = tlep_pkg::ST_NONE;
					state_d = tlep_pkg::S_EMIT_STATUS;
				end else if (stat.bad_tier) begin
					code_d  = tlep_pkg::ST_BAD_TIER;
					state_d = tlep_pkg::S_EMIT_STATUS;
				end else begin
					case (stat.req) inside
						tlep_pkg::REQ_PUT, tlep_pkg::REQ_ACCESS, tlep_pkg::REQ_DELETE: begin
							cmd.op  = tlep_pkg::OP_SCAN_INIT;
							state_d = tlep_pkg::S_SCAN;
						end
						tlep_pkg::REQ_EVICT_KEY: begin
							if (stat.ek_empty) begin
								code_d  = tlep_pkg::ST_NONE;
								state_d = tlep_pkg::S_EMIT_STATUS;
							end else begin
								cmd.op  = tlep_pkg::OP_PLAN_RD;
								state_d = tlep_pkg::S_PLAN_EMIT;
							end
						end
						tlep_pkg::REQ_PROMOTE: begin
							if (stat.pr_empty) begin
								code_d  = tlep_pkg::ST_NONE;
								state_d = tlep_pkg::S_EMIT_STATUS;
							end else begin
								cmd.op  = tlep_pkg::OP_PLAN_RD;
								state_d = tlep_pkg::S_PLAN_EMIT;
							end
						end
						default: begin
							if (stat.eb_empty) begin
								code_d  = tlep_pkg::ST_NONE;
								state_d = tlep_pkg::S_EMIT_STATUS;
							end else begin
								cmd.op  = tlep_pkg::OP_EB_INIT;
								state_d = tlep_pkg::S_EB_EMIT;
							end
						end
					endcase
				end
			end
			tlep_pkg::S_SCAN: begin
				cmd.op = tlep_pkg::OP_SCAN;
				if (stat.scan_hit) begin
					state_d = tlep_pkg::S_ENT_RD;
				end else if (stat.scan_done) begin
					if (stat.req == tlep_pkg::REQ_PUT && stat.free_found) begin
						state_d = tlep_pkg::S_APPEND1;
					end else begin
						code_d  = (stat.req == tlep_pkg::REQ_PUT) ? tlep_pkg::ST_FULL
							: tlep_pkg::ST_NONE;
						state_d = tlep_pkg::S_EMIT_STATUS;
					end
				end
			end
			tlep_pkg::S_ENT_RD: begin
				cmd.op  = tlep_pkg::OP_ENT_RD;
				state_d = tlep_pkg::S_UNLINK;
			end
			tlep_pkg::S_UNLINK: begin
				cmd.op = tlep_pkg::OP_UNLINK;
				if (stat.req == tlep_pkg::REQ_DELETE) begin
					code_d  = tlep_pkg::ST_DONE;
					state_d = tlep_pkg::S_EMIT_STATUS;
				end else begin
					state_d = tlep_pkg::S_APPEND1;
				end
			end
			tlep_pkg::S_APPEND1: begin
				cmd.op  = tlep_pkg::OP_APPEND1;
				state_d = tlep_pkg::S_APPEND2;
			end
			tlep_pkg::S_APPEND2: begin
				cmd.op  = tlep_pkg::OP_APPEND2;
				code_d  = tlep_pkg::ST_DONE;
				state_d = tlep_pkg::S_EMIT_STATUS;
			end
			tlep_pkg::S_PLAN_EMIT: begin
				if (stat.slot_free) begin
					cmd.op  = tlep_pkg::OP_PLAN_EMIT;
					state_d = tlep_pkg::S_IDLE;
				end
			end
			tlep_pkg::S_EB_EMIT: begin
				if (stat.slot_free) begin
					cmd.op = tlep_pkg::OP_EB_EMIT;
					if (stat.eb_last) begin
						state_d = tlep_pkg::S_IDLE;
					end
				end
			end
			tlep_pkg::S_EMIT_STATUS: begin
				if (stat.slot_free) begin
					cmd.op  = tlep_pkg::OP_EMIT_STATUS;
					state_d = tlep_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = tlep_pkg::S_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

// ===== hdl/tlep_dp.sv =====
`default_nettype none
module tlep_dp #(
	parameter int ENTRIES   = 64,
	parameter int NUM_TIERS = 4,
	parameter int KEY_BITS  = 32
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire tlep_pkg::cfg_t        cfg,
	input  wire tlep_pkg::dp_cmd_t     cmd,
	output tlep_pkg::dp_stat_t         stat,
	input  wire logic [2:0]            req_type,
	input  wire logic [KEY_BITS-1:0]   key_id,
	input  wire logic [1:0]            tier_sel,
	input  wire logic [31:0]           item_size,
	input  wire logic [31:0]           bytes_wanted,
	input  wire logic                  out_stall,
	output logic                       out_valid,
	output logic [1:0]                 status,
	output logic                       plan_valid,
	output logic [KEY_BITS-1:0]        plan_key,
	output logic [1:0]                 source_tier,
	output logic [1:0]                 dest_tier,
	output logic                       discard,
	output logic                       last
);

	localparam int AW = $clog2(ENTRIES);
	localparam int CW = $clog2(ENTRIES + 1);
	localparam int TW = (NUM_TIERS > 1) ? $clog2(NUM_TIERS) : 1;
	localparam int PW = tlep_pkg::PLAN_CNT_W;

	// request
	tlep_pkg::req_t      req_q;
	logic [KEY_BITS-1:0] key_q;
	logic [1:0]          t_q;
	logic [31:0]         size_q;
	logic [31:0]         want_q;

	// entry store
	logic                valid_q [ENTRIES];
	logic [KEY_BITS-1:0] key_mem [ENTRIES];
	logic [31:0]         size_mem [ENTRIES];
	logic [1:0]          tier_mem [ENTRIES];
	logic [AW-1:0]       prev_mem [ENTRIES];
	logic [AW-1:0]       next_mem [ENTRIES];
	logic [KEY_BITS-1:0] key_rd_q;
	logic [31:0]         size_rd_q;
	logic [1:0]          tier_rd_q;
	logic [AW-1:0]       prev_rd_q;
	logic [AW-1:0]       next_rd_q;

	// per tier lists
	logic [AW-1:0] head_q  [NUM_TIERS];
	logic [AW-1:0] tail_q  [NUM_TIERS];
	logic [CW-1:0] count_q [NUM_TIERS];

	// scan and walk
	logic [AW:0]   idx_q;
	logic          cmp_vld_q;
	logic [AW-1:0] cmp_idx_q;
	logic          free_found_q;
	logic [AW-1:0] free_idx_q;
	logic [AW-1:0] e_q;
	logic [1:0]    own_q;
	logic [CW-1:0] left_q;
	logic [PW-1:0] n_q;
	logic [31:0]   freed_q;

	// result
	logic                out_valid_q;
	tlep_pkg::status_t   res_status_q;
	logic                res_plan_q;
	logic [KEY_BITS-1:0] res_key_q;
	logic [1:0]          res_src_q;
	logic [1:0]          res_dst_q;
	logic                res_discard_q;
	logic                res_last_q;

	logic [3:0]    active;
	logic [3:0]    nt;
	logic          nt_act;
	logic [TW-1:0] ti, nti, oi, ati;
	logic [1:0]    at2;
	logic [31:0]   fs;
	logic          tgt_discard;
	logic [1:0]    tgt_dest;
	logic [32:0]   eb_sum;
	logic          scan_live;
	logic          slot_free;
	logic          emit;

	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic          ent_we, sz_we, pv_we, nx_we;
	logic [AW-1:0] pv_wa, pv_wd, nx_wa, nx_wd;

	always_comb begin
		if (cfg.tiers_in_use == 3'd0) begin
			active = 4'd1;
		end else if ({1'b0, cfg.tiers_in_use} > 4'(NUM_TIERS)) begin
			active = 4'(NUM_TIERS);
		end else begin
			active = {1'b0, cfg.tiers_in_use};
		end
	end

	assign nt     = {2'b00, t_q} + 4'd1;
	assign nt_act = nt < active;
	assign ti     = TW'(t_q);
	assign nti    = TW'(nt);
	assign oi     = TW'(tier_rd_q);
	assign at2    = (req_q == tlep_pkg::REQ_ACCESS) ? own_q : t_q;
	assign ati    = TW'(at2);

	// free space of the next tier, none above tier three
	always_comb begin
		case (nt)
			4'd1:    fs = cfg.free_one;
			4'd2:    fs = cfg.free_two;
			4'd3:    fs = cfg.free_three;
			default: fs = '0;
		endcase
	end

	assign tgt_discard = !(nt_act && (fs >= size_rd_q));
	assign tgt_dest    = tgt_discard ? 2'd0 : nt[1:0];
	assign eb_sum      = {1'b0, freed_q} + {1'b0, size_rd_q};
	assign scan_live   = idx_q < (AW + 1)'(ENTRIES);
	assign slot_free   = !out_valid_q || !out_stall;
	assign emit        = (cmd.op == tlep_pkg::OP_PLAN_EMIT) || (cmd.op == tlep_pkg::OP_EB_EMIT)
		|| (cmd.op == tlep_pkg::OP_EMIT_STATUS);

	always_comb begin
		stat.req        = req_q;
		stat.bad_req    = req_q > tlep_pkg::REQ_EVICT_BYTES;
		stat.bad_tier   = {2'b00, t_q} >= active;
		stat.ek_empty   = count_q[ti] == '0;
		stat.pr_empty   = !nt_act || (count_q[nti] == '0);
		stat.eb_empty   = (want_q == '0) || (count_q[ti] == '0);
		stat.scan_hit   = cmp_vld_q && valid_q[cmp_idx_q] && (key_rd_q == key_q);
		stat.scan_done  = cmp_vld_q && (cmp_idx_q == AW'(ENTRIES - 1));
		stat.free_found = free_found_q;
		stat.eb_last    = (eb_sum >= {1'b0, want_q}) || (left_q == CW'(1))
			|| (n_q == PW'(tlep_pkg::MAX_RESULTS - 1));
		stat.slot_free  = slot_free;
	end

	// memory port control
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = e_q;
		ent_we  = 1'b0;
		sz_we   = 1'b0;
		pv_we   = 1'b0;
		pv_wa   = e_q;
		pv_wd   = tail_q[ati];
		nx_we   = 1'b0;
		nx_wa   = e_q;
		nx_wd   = '0;
		case (cmd.op)
			tlep_pkg::OP_SCAN: begin
				rd_en   = scan_live;
				rd_addr = idx_q[AW-1:0];
			end
			tlep_pkg::OP_ENT_RD: begin
				rd_en = 1'b1;
			end
			tlep_pkg::OP_PLAN_RD: begin
				rd_en   = 1'b1;
				rd_addr = (req_q == tlep_pkg::REQ_EVICT_KEY) ? head_q[ti] : tail_q[nti];
			end
			tlep_pkg::OP_EB_INIT: begin
				rd_en   = 1'b1;
				rd_addr = head_q[ti];
			end
			tlep_pkg::OP_EB_EMIT: begin
				rd_en   = 1'b1;
				rd_addr = next_rd_q;
			end
			tlep_pkg::OP_UNLINK: begin
				if (head_q[oi] != e_q) begin
					nx_we = 1'b1;
					nx_wa = prev_rd_q;
					nx_wd = next_rd_q;
				end
				if (tail_q[oi] != e_q) begin
					pv_we = 1'b1;
					pv_wa = next_rd_q;
					pv_wd = prev_rd_q;
				end
			end
			tlep_pkg::OP_APPEND1: begin
				ent_we = 1'b1;
				sz_we  = req_q == tlep_pkg::REQ_PUT;
				pv_we  = 1'b1;
				nx_we  = 1'b1;
			end
			tlep_pkg::OP_APPEND2: begin
				if (count_q[ati] != '0) begin
					nx_we = 1'b1;
					nx_wa = tail_q[ati];
					nx_wd = e_q;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ent_we) begin
			tier_mem[e_q] <= at2;
		end
		if (sz_we) begin
			key_mem[e_q]  <= key_q;
			size_mem[e_q] <= size_q;
		end
		if (pv_we) begin
			prev_mem[pv_wa] <= pv_wd;
		end
		if (nx_we) begin
			next_mem[nx_wa] <= nx_wd;
		end
		if (rd_en) begin
			key_rd_q  <= key_mem[rd_addr];
			size_rd_q <= size_mem[rd_addr];
			tier_rd_q <= tier_mem[rd_addr];
			prev_rd_q <= prev_mem[rd_addr];
			next_rd_q <= next_mem[rd_addr];
		end
	end

	// list heads and tails
	always_ff @(posedge clk) begin
		case (cmd.op)
			tlep_pkg::OP_UNLINK: begin
				if (head_q[oi] == e_q) begin
					head_q[oi] <= next_rd_q;
				end
				if (tail_q[oi] == e_q) begin
					tail_q[oi] <= prev_rd_q;
				end
			end
			tlep_pkg::OP_APPEND2: begin
				if (count_q[ati] == '0) begin
					head_q[ati] <= e_q;
				end
				tail_q[ati] <= e_q;
			end
			default: ;
		endcase
	end

	// valid bits and list lengths
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ENTRIES; i++) begin
				valid_q[i] <= 1'b0;
			end
			for (int k = 0; k < NUM_TIERS; k++) begin
				count_q[k] <= '0;
			end
		end else begin
			case (cmd.op)
				tlep_pkg::OP_SCAN: begin
					if (!stat.scan_hit && stat.scan_done && req_q == tlep_pkg::REQ_PUT
						&& free_found_q) begin
						valid_q[free_idx_q] <= 1'b1;
					end
				end
				tlep_pkg::OP_UNLINK: begin
					count_q[oi] <= count_q[oi] - CW'(1);
					if (req_q == tlep_pkg::REQ_DELETE) begin
						valid_q[e_q] <= 1'b0;
					end
				end
				tlep_pkg::OP_APPEND2: begin
					count_q[ati] <= count_q[ati] + CW'(1);
				end
				default: ;
			endcase
		end
	end

	// request, scan and walk registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			tlep_pkg::OP_LOAD: begin
				req_q  <= req_type;
				key_q  <= key_id;
				t_q    <= tier_sel;
				size_q <= item_size;
				want_q <= bytes_wanted;
			end
			tlep_pkg::OP_SCAN_INIT: begin
				idx_q        <= '0;
				cmp_vld_q    <= 1'b0;
				free_found_q <= 1'b0;
			end
			tlep_pkg::OP_SCAN: begin
				cmp_vld_q <= scan_live;
				cmp_idx_q <= idx_q[AW-1:0];
				if (scan_live) begin
					idx_q <= idx_q + (AW + 1)'(1);
					if (!free_found_q && !valid_q[idx_q[AW-1:0]]) begin
						free_found_q <= 1'b1;
						free_idx_q   <= idx_q[AW-1:0];
					end
				end
				if (stat.scan_hit) begin
					e_q <= cmp_idx_q;
				end else if (stat.scan_done) begin
					e_q <= free_idx_q;
				end
			end
			tlep_pkg::OP_UNLINK: begin
				own_q <= tier_rd_q;
			end
			tlep_pkg::OP_EB_INIT: begin
				left_q  <= count_q[ti];
				n_q     <= '0;
				freed_q <= '0;
			end
			tlep_pkg::OP_EB_EMIT: begin
				left_q  <= left_q - CW'(1);
				n_q     <= n_q + PW'(1);
				freed_q <= eb_sum[31:0];
			end
			default: ;
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			tlep_pkg::OP_PLAN_EMIT: begin
				res_status_q <= tlep_pkg::ST_DONE;
				res_plan_q   <= 1'b1;
				res_key_q    <= key_rd_q;
				res_last_q   <= 1'b1;
				if (req_q == tlep_pkg::REQ_EVICT_KEY) begin
					res_src_q     <= t_q;
					res_dst_q     <= tgt_dest;
					res_discard_q <= tgt_discard;
				end else begin
					res_src_q     <= nt[1:0];
					res_dst_q     <= t_q;
					res_discard_q <= 1'b0;
				end
			end
			tlep_pkg::OP_EB_EMIT: begin
				res_status_q  <= tlep_pkg::ST_DONE;
				res_plan_q    <= 1'b1;
				res_key_q     <= key_rd_q;
				res_src_q     <= t_q;
				res_dst_q     <= tgt_dest;
				res_discard_q <= tgt_discard;
				res_last_q    <= stat.eb_last;
			end
			tlep_pkg::OP_EMIT_STATUS: begin
				res_status_q  <= cmd.code;
				res_plan_q    <= 1'b0;
				res_key_q     <= '0;
				res_src_q     <= 2'd0;
				res_dst_q     <= 2'd0;
				res_discard_q <= 1'b0;
				res_last_q    <= 1'b1;
			end
			default: ;
		endcase
	end

	assign out_valid   = out_valid_q;
	assign status      = res_status_q;
	assign plan_valid  = res_plan_q;
	assign plan_key    = res_key_q;
	assign source_tier = res_src_q;
	assign dest_tier   = res_dst_q;
	assign discard     = res_discard_q;
	assign last        = res_last_q;

endmodule
`default_nettype wire

// ===== hdl/tlep_checker.sv =====
`default_nettype none
module tlep_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_stall,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic       plan_valid,
	input wire logic [1:0] dest_tier,
	input wire logic       discard,
	input wire logic       last
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// one request at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("request taken while busy");

	// plans of one request follow without a gap
	a_burst_gapless: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last |=> out_valid)
		else $error("gap inside a plan burst");

	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !plan_valid |-> last)
		else $error("status result not last");

	a_discard_dest: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && discard |-> plan_valid && dest_tier == 2'd0)
		else $error("discard with a destination");

endmodule

bind tiered_lru_eviction_planner tlep_checker u_chk (.*);
`default_nettype wire

// ===== sim/tlep_checker.sv =====
`timescale 1ns / 100ps
module tlep_scoreboard (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	input  wire logic        pready,
	input  wire logic        in_valid,
	input  wire logic        in_stall,
	input  wire logic [2:0]  req_type,
	input  wire logic [31:0] key_id,
	input  wire logic [1:0]  tier_sel,
	input  wire logic [31:0] item_size,
	input  wire logic [31:0] bytes_wanted,
	input  wire logic        out_valid,
	input  wire logic        out_stall,
	input  wire logic [1:0]  status,
	input  wire logic        plan_valid,
	input  wire logic [31:0] plan_key,
	input  wire logic [1:0]  source_tier,
	input  wire logic [1:0]  dest_tier,
	input  wire logic        discard,
	input  wire logic        last,
	output int               mismatches,
	output int               outstanding
);

	localparam int SLOTS = 64;
	localparam int TIERS = 4;

	typedef struct {
		tlep_pkg::status_t st;
		logic        plan;
		logic [31:0] key;
		logic [1:0]  src;
		logic [1:0]  dst;
		logic        drop;
		logic        fin;
	} move_plan_t;

	move_plan_t  plan_queue[$];
	logic [2:0]  tiers_cfg;
	logic [31:0] free_bytes[1:3];
	bit          used[SLOTS];
	logic [31:0] slot_key[SLOTS];
	int          slot_tier[SLOTS];
	logic [31:0] slot_size[SLOTS];
	int          slot_prev[SLOTS];
	int          slot_next[SLOTS];
	int          lru_head[TIERS];
	int          mru_tail[TIERS];
	int          tier_len[TIERS];

	function automatic int live_tiers();
		if (tiers_cfg == 0)
			return 1;
		if (tiers_cfg > TIERS)
			return TIERS;
		return int'(tiers_cfg);
	endfunction

	function automatic int find_slot(logic [31:0] key);
		for (int i = 0; i < SLOTS; i++)
			if (used[i] && slot_key[i] == key)
				return i;
		return -1;
	endfunction

	function automatic int move_dest(int t, logic [31:0] size);
		int nt;
		nt = t + 1;
		if (nt >= live_tiers())
			return -1;
		return (free_bytes[nt] >= size) ? nt : -1;
	endfunction

	task automatic unlink_slot(int i);
		int t;
		t = slot_tier[i];
		if (lru_head[t] == i) lru_head[t] = slot_next[i];
		else slot_next[slot_prev[i]] = slot_next[i];
		if (mru_tail[t] == i) mru_tail[t] = slot_prev[i];
		else slot_prev[slot_next[i]] = slot_prev[i];
		tier_len[t]--;
	endtask

	task automatic append_slot(int i, int t);
		slot_tier[i] = t;
		slot_prev[i] = mru_tail[t];
		slot_next[i] = 0;
		if (tier_len[t] == 0) lru_head[t] = i;
		else slot_next[mru_tail[t]] = i;
		mru_tail[t] = i;
		tier_len[t]++;
	endtask

	task automatic push_plan(tlep_pkg::status_t st, bit plan, logic [31:0] key, int src,
			int dst, bit fin);
		move_plan_t p;
		p.st = st;
		p.plan = plan;
		p.key = plan ? key : '0;
		p.src = plan ? src[1:0] : '0;
		p.dst = (plan && dst >= 0) ? dst[1:0] : '0;
		p.drop = plan && dst < 0;
		p.fin = fin;
		plan_queue.insert(plan_queue.size(), p);
	endtask

	task automatic predict_request(tlep_pkg::req_t req, logic [31:0] key, int t,
			logic [31:0] size, logic [31:0] wanted);
		int i, own, nt, left, n;
		logic [32:0] freed;
		if (req > tlep_pkg::REQ_EVICT_BYTES) begin
			push_plan(tlep_pkg::ST_NONE, 0, 0, 0, 0, 1);
		end else if (t >= live_tiers()) begin
			push_plan(tlep_pkg::ST_BAD_TIER, 0, 0, 0, 0, 1);
		end else if (req == tlep_pkg::REQ_PUT) begin
			i = find_slot(key);
			if (i >= 0) begin
				unlink_slot(i);
			end else begin
				for (int j = 0; j < SLOTS; j++)
					if (!used[j] && i < 0)
						i = j;
			end
			if (i < 0) begin
				push_plan(tlep_pkg::ST_FULL, 0, 0, 0, 0, 1);
			end else begin
				used[i] = 1;
				slot_key[i] = key;
				slot_size[i] = size;
				append_slot(i, t);
				push_plan(tlep_pkg::ST_DONE, 0, 0, 0, 0, 1);
			end
		end else if (req == tlep_pkg::REQ_ACCESS || req == tlep_pkg::REQ_DELETE) begin
			i = find_slot(key);
			if (i < 0) begin
				push_plan(tlep_pkg::ST_NONE, 0, 0, 0, 0, 1);
			end else begin
				own = slot_tier[i];
				unlink_slot(i);
				if (req == tlep_pkg::REQ_ACCESS) append_slot(i, own);
				else used[i] = 0;
				push_plan(tlep_pkg::ST_DONE, 0, 0, 0, 0, 1);
			end
		end else if (req == tlep_pkg::REQ_EVICT_KEY) begin
			if (tier_len[t] == 0) begin
				push_plan(tlep_pkg::ST_NONE, 0, 0, 0, 0, 1);
			end else begin
				i = lru_head[t];
				push_plan(tlep_pkg::ST_DONE, 1, slot_key[i], t,
					move_dest(t, slot_size[i]), 1);
			end
		end else if (req == tlep_pkg::REQ_PROMOTE) begin
			nt = t + 1;
			if (nt >= live_tiers() || tier_len[nt] == 0) begin
				push_plan(tlep_pkg::ST_NONE, 0, 0, 0, 0, 1);
			end else begin
				i = mru_tail[nt];
				push_plan(tlep_pkg::ST_DONE, 1, slot_key[i], nt, t, 1);
			end
		end else begin
			freed = 0;
			left = tier_len[t];
			i = lru_head[t];
			n = 0;
			while (freed < {1'b0, wanted} && left > 0 && n < tlep_pkg::MAX_RESULTS) begin
				push_plan(tlep_pkg::ST_DONE, 1, slot_key[i], t,
					move_dest(t, slot_size[i]), 0);
				freed += {1'b0, slot_size[i]};
				n++;
				left--;
				i = slot_next[i];
			end
			if (n == 0) push_plan(tlep_pkg::ST_NONE, 0, 0, 0, 0, 1);
			else plan_queue[plan_queue.size() - 1].fin = 1;
		end
	endtask

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("%0t: mismatch in %s: got %0h, expected %0h", $realtime, what, got, want);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		move_plan_t p;
		if (!arst_n) begin
			tiers_cfg = 1;
			for (int k = 1; k <= 3; k++)
				free_bytes[k] = 0;
			for (int k = 0; k < SLOTS; k++)
				used[k] = 0;
			for (int k = 0; k < TIERS; k++) begin
				tier_len[k] = 0;
				lru_head[k] = 0;
				mru_tail[k] = 0;
			end
			plan_queue.delete();
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (tlep_pkg::reg_addr_t'(paddr[3:2]))
					tlep_pkg::REG_TIERS:      tiers_cfg = pwdata[2:0];
					tlep_pkg::REG_FREE_ONE:   free_bytes[1] = pwdata;
					tlep_pkg::REG_FREE_TWO:   free_bytes[2] = pwdata;
					tlep_pkg::REG_FREE_THREE: free_bytes[3] = pwdata;
				endcase
			end
			if (in_valid && !in_stall)
				predict_request(req_type, key_id, int'(tier_sel), item_size, bytes_wanted);
			if (out_valid && !out_stall) begin
				if (plan_queue.size() == 0) begin
					report("unexpected result", {30'd0, status}, 0);
				end else begin
					p = plan_queue.pop_front();
					if (status !== p.st) report("status", 32'(status), 32'(p.st));
					if (plan_valid !== p.plan)
						report("plan_valid", 32'(plan_valid), 32'(p.plan));
					if (plan_key !== p.key) report("plan_key", plan_key, p.key);
					if (source_tier !== p.src)
						report("source_tier", 32'(source_tier), 32'(p.src));
					if (dest_tier !== p.dst)
						report("dest_tier", 32'(dest_tier), 32'(p.dst));
					if (discard !== p.drop) report("discard", 32'(discard), 32'(p.drop));
					if (last !== p.fin) report("last", 32'(last), 32'(p.fin));
				end
			end
		end
		outstanding = plan_queue.size();
	end

	initial begin
		mismatches = 0;
		outstanding = 0;
	end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
module tb;

	localparam int CYCLE_LIMIT = 5000000;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        psel = 0;
	logic        penable = 0;
	logic        pwrite = 0;
	logic [3:0]  paddr = 0;
	logic [31:0] pwdata = 0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid = 0;
	logic        in_stall;
	logic [2:0]  req_type = 0;
	logic [31:0] key_id = 0;
	logic [1:0]  tier_sel = 0;
	logic [31:0] item_size = 0;
	logic [31:0] bytes_wanted = 0;
	logic        out_valid;
	logic        out_stall = 0;
	logic [1:0]  status;
	logic        plan_valid;
	logic [31:0] plan_key;
	logic [1:0]  source_tier;
	logic [1:0]  dest_tier;
	logic        discard;
	logic        last;
	int          mismatches;
	int          outstanding;
	int          cycles = 0;
	int          stall_run = 0;
	logic [31:0] key_pool[12];

	always #6 clk = ~clk;

	tiered_lru_eviction_planner u_dut (.*);

	tlep_scoreboard u_checker (.*);

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: FAIL");
			$finish;
		end
	end

	// receiver stalls in runs
	always @(posedge clk) begin
		if (stall_run > 0) begin
			stall_run <= stall_run - 1;
		end else begin
			out_stall <= ($urandom_range(0, 2) == 0);
			stall_run <= ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40)
				: $urandom_range(0, 3);
		end
	end

	function automatic int pick_gap();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return 0;
			9: return $urandom_range(15, 40);
			default: return $urandom_range(1, 3);
		endcase
	endfunction

	task automatic send_request(tlep_pkg::req_t req, logic [31:0] key, logic [1:0] t,
			logic [31:0] size, logic [31:0] wanted);
		int gap;
		in_valid <= 1;
		req_type <= req;
		key_id <= key;
		tier_sel <= t;
		item_size <= size;
		bytes_wanted <= wanted;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic reg_write(tlep_pkg::reg_addr_t idx, logic [31:0] value);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
	endtask

	task automatic settle_and_configure(logic [2:0] tiers, logic [31:0] f1, logic [31:0] f2,
			logic [31:0] f3);
		in_valid <= 0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		reg_write(tlep_pkg::REG_TIERS, {29'd0, tiers});
		reg_write(tlep_pkg::REG_FREE_ONE, f1);
		reg_write(tlep_pkg::REG_FREE_TWO, f2);
		reg_write(tlep_pkg::REG_FREE_THREE, f3);
	endtask

	function automatic logic [31:0] pick_key();
		if ($urandom_range(0, 9) < 8)
			return key_pool[$urandom_range(0, 11)];
		return $urandom;
	endfunction

	task automatic random_request();
		int r;
		tlep_pkg::req_t req;
		logic [31:0] size, wanted;
		r = $urandom_range(0, 99);
		if (r < 33) req = tlep_pkg::REQ_PUT;
		else if (r < 48) req = tlep_pkg::REQ_ACCESS;
		else if (r < 63) req = tlep_pkg::REQ_DELETE;
		else if (r < 74) req = tlep_pkg::REQ_EVICT_KEY;
		else if (r < 85) req = tlep_pkg::REQ_PROMOTE;
		else if (r < 97) req = tlep_pkg::REQ_EVICT_BYTES;
		else req = tlep_pkg::req_t'($urandom_range(6, 7));
		size = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 200);
		wanted = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 400);
		send_request(req, pick_key(), 2'($urandom_range(0, 3)), size, wanted);
	endtask

	initial begin
		key_pool[0] = 32'h0;
		key_pool[1] = 32'hffff_ffff;
		for (int k = 2; k < 12; k++)
			key_pool[k] = $urandom;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		reg_write(tlep_pkg::REG_TIERS, 4);
		reg_write(tlep_pkg::REG_FREE_ONE, 32'hffff_ffff);
		reg_write(tlep_pkg::REG_FREE_TWO, 0);
		reg_write(tlep_pkg::REG_FREE_THREE, $urandom);

		send_request(tlep_pkg::REQ_PUT, 32'h0, 0, 0, 0);
		send_request(tlep_pkg::REQ_PUT, 32'hffff_ffff, 3, 32'hffff_ffff, 32'hffff_ffff);
		send_request(tlep_pkg::REQ_PUT, 32'h5, 1, 10, 0);
		send_request(tlep_pkg::REQ_PUT, 32'h5, 2, 20, 0);
		send_request(tlep_pkg::REQ_ACCESS, 32'h5, 0, 0, 0);
		send_request(tlep_pkg::REQ_ACCESS, 32'h77, 0, 0, 0);
		send_request(tlep_pkg::REQ_DELETE, 32'h78, 1, 0, 0);
		send_request(tlep_pkg::REQ_EVICT_KEY, 0, 0, 0, 0);
		send_request(tlep_pkg::REQ_EVICT_KEY, 0, 3, 0, 0);
		send_request(tlep_pkg::REQ_EVICT_KEY, 0, 1, 0, 0);
		send_request(tlep_pkg::REQ_PROMOTE, 0, 2, 0, 0);
		send_request(tlep_pkg::REQ_PROMOTE, 0, 3, 0, 0);
		send_request(tlep_pkg::REQ_PROMOTE, 0, 0, 0, 0);
		send_request(tlep_pkg::REQ_EVICT_BYTES, 0, 3, 0, 0);
		send_request(tlep_pkg::REQ_EVICT_BYTES, 0, 0, 0, 32'hffff_ffff);
		send_request(tlep_pkg::REQ_EVICT_BYTES, 0, 1, 0, 5);
		send_request(tlep_pkg::req_t'(6), 32'h5, 0, 0, 0);
		send_request(tlep_pkg::req_t'(7), 32'h5, 0, 0, 0);
		send_request(tlep_pkg::REQ_DELETE, 32'h5, 3, 0, 0);
		send_request(tlep_pkg::REQ_DELETE, 32'h0, 0, 0, 0);

		settle_and_configure(0, 0, 32'hffff_ffff, 0);
		send_request(tlep_pkg::REQ_PUT, 32'h9, 1, 1, 0);
		send_request(tlep_pkg::REQ_EVICT_KEY, 0, 0, 0, 0);

		settle_and_configure(7, $urandom_range(0, 300), $urandom, 32'hffff_ffff);
		repeat (12) random_request();

		// fill the store to capacity, then plan a full sweep
		settle_and_configure(2, 0, 32'hffff_ffff, 0);
		for (int k = 0; k < 66; k++)
			send_request(tlep_pkg::REQ_PUT, 32'h1000 + k, 0, $urandom_range(0, 50), 0);
		send_request(tlep_pkg::REQ_EVICT_BYTES, 0, 0, 0, 32'hffff_ffff);
		send_request(tlep_pkg::REQ_PROMOTE, 0, 0, 0, 0);
		for (int k = 0; k < 4; k++)
			send_request(tlep_pkg::REQ_DELETE, 32'h1000 + $urandom_range(0, 65), 0, 0, 0);

		settle_and_configure(3, $urandom_range(0, 200), $urandom_range(0, 200), $urandom);
		repeat (6) random_request();

		in_valid <= 0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

endmodule
